// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file. Each macro samples on
// clk and is switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VSA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vsa assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define VSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vsa assertion failed");

`endif

// ===== rtl/core/vsa_pkg.sv =====
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared constants, command codes and the token and commit structures of the
// voice slot allocator.
// ----------------------------------------------------------------------------
package vsa_pkg;

  // Pool size and derived widths
  localparam int NUM_SLOTS = 16;
  localparam int SEL_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int ID_W    = 16;
  localparam int CH_W    = 8;
  localparam int SLOT_W  = 8;
  localparam int STAMP_W = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ASSIGN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  // Request token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic               valid;
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  idx;
    logic               found;
    logic [STAMP_W-1:0] best_stamp;
    logic [SEL_W-1:0]   best_idx;
    logic [ID_W-1:0]    owner_id;
    logic [CH_W-1:0]    owner_ch;
  } tok_t;

  // Write of the chosen slot at the end of an assign
  typedef struct packed {
    logic               en;
    logic [SEL_W-1:0]   sel;
    logic [ID_W-1:0]    eid;
    logic [CH_W-1:0]    ech;
    logic [STAMP_W-1:0] stamp;
  } commit_t;

endpackage

// ===== rtl/core/voice_slot_allocator_oldest_steal.sv =====
// ----------------------------------------------------------------------------
// voice_slot_allocator_oldest_steal
// Pool of playback slots with lowest-free assignment and oldest-first steal.
// ----------------------------------------------------------------------------
// Usage: raise start with in_command and its fields while busy is low; the
// request is taken at that edge and busy rises. Assign takes the lowest free
// slot, or steals the one with the smallest stamp (ties to the lower index)
// and sets out_stolen. Release frees a slot, query returns its owner; an
// index beyond the pool sets out_status and changes nothing.
// Every request gives one result, shown for exactly one cycle with
// out_strobe; the receiver cannot stall, so it must sample then.
// The request token walks the slot cell chain one cell per cycle, and the
// result is registered from the token as it leaves the last cell.
// busy falls as the strobe rises, so a new request can be taken in the strobe
// cycle; no new request is taken while busy is high.
// Reset (rst_n low, synchronous) frees every slot, clears owners, stamps and
// the stamp counter, and drops busy and out_strobe.
// ----------------------------------------------------------------------------
module voice_slot_allocator_oldest_steal (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [vsa_pkg::CMD_W-1:0]   in_command,
  input  logic [vsa_pkg::ID_W-1:0]    in_entity_id,
  input  logic [vsa_pkg::CH_W-1:0]    in_entity_channel,
  input  logic [vsa_pkg::SLOT_W-1:0]  in_slot_index,
  output logic                        out_strobe,
  output logic [vsa_pkg::SLOT_W-1:0]  out_slot_index_out,
  output logic [vsa_pkg::ID_W-1:0]    out_owner_id,
  output logic [vsa_pkg::CH_W-1:0]    out_owner_channel,
  output logic                        out_stolen,
  output logic                        out_status
);
  import vsa_pkg::*;

  tok_t               tok [NUM_SLOTS+1];
  tok_t               tok_last;
  commit_t            commit;
  logic               accept;
  logic               busy_r,    busy_nxt;
  logic [ID_W-1:0]    req_eid_r;
  logic [CH_W-1:0]    req_ech_r;
  logic [STAMP_W-1:0] stamp_cnt_r;
  logic               in_range;

  logic               strobe_r;
  logic [SLOT_W-1:0]  slot_r,    slot_nxt;
  logic [ID_W-1:0]    oid_r,     oid_nxt;
  logic [CH_W-1:0]    och_r,     och_nxt;
  logic               stolen_r,  stolen_nxt;
  logic               status_r,  status_nxt;

  assign accept = start && !busy_r;

  // Launch a fresh token into the first cell
  always_comb begin
    tok[0]            = '0;
    tok[0].valid      = accept;
    tok[0].cmd        = in_command;
    tok[0].idx        = in_slot_index;
    tok[0].best_stamp = '1;
  end

  // Chain of slot cells
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    vsa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SEL_W'(g)),
      .tok_i    (tok[g]),
      .commit   (commit),
      .tok_o    (tok[g+1])
    );
  end

  assign tok_last = tok[NUM_SLOTS];
  assign in_range = ({1'b0, tok_last.idx} < (SLOT_W+1)'(NUM_SLOTS));

  // Write the chosen slot when the assign token leaves the chain
  always_comb begin
    commit.en    = tok_last.valid && (tok_last.cmd == CMD_ASSIGN);
    commit.sel   = tok_last.best_idx;
    commit.eid   = req_eid_r;
    commit.ech   = req_ech_r;
    commit.stamp = stamp_cnt_r + STAMP_W'(1);
  end

  // Form the result
  always_comb begin
    slot_nxt   = '0;
    oid_nxt    = '0;
    och_nxt    = '0;
    stolen_nxt = 1'b0;
    status_nxt = 1'b0;
    case (tok_last.cmd)
      CMD_ASSIGN: begin
        slot_nxt   = SLOT_W'(tok_last.best_idx);
        stolen_nxt = !tok_last.found;
      end
      CMD_RELEASE: begin
        slot_nxt   = tok_last.idx;
        status_nxt = !in_range;
      end
      CMD_QUERY: begin
        slot_nxt   = tok_last.idx;
        oid_nxt    = tok_last.owner_id;
        och_nxt    = tok_last.owner_ch;
        status_nxt = !in_range;
      end
      default: begin
      end
    endcase
  end

  // Set busy on a request, drop it as the result goes out
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (tok_last.valid) begin
      busy_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      strobe_r    <= 1'b0;
      stamp_cnt_r <= '0;
    end else begin
      busy_r   <= busy_nxt;
      strobe_r <= tok_last.valid;
      if (commit.en) begin
        stamp_cnt_r <= commit.stamp;
      end
    end
  end

  // Hold request payload and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_eid_r <= in_entity_id;
      req_ech_r <= in_entity_channel;
    end
    if (tok_last.valid) begin
      slot_r   <= slot_nxt;
      oid_r    <= oid_nxt;
      och_r    <= och_nxt;
      stolen_r <= stolen_nxt;
      status_r <= status_nxt;
    end
  end

  assign busy               = busy_r;
  assign out_strobe         = strobe_r;
  assign out_slot_index_out = slot_r;
  assign out_owner_id       = oid_r;
  assign out_owner_channel  = och_r;
  assign out_stolen         = stolen_r;
  assign out_status         = status_r;

endmodule

// ===== rtl/core/vsa_cell.sv =====
// ----------------------------------------------------------------------------
// vsa_cell
// One slot of the pool. Holds the slot state, updates the passing request
// token (free search, oldest search, release, query) and hands it on.
// ----------------------------------------------------------------------------
module vsa_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [vsa_pkg::SEL_W-1:0] cell_idx,
  input  vsa_pkg::tok_t           tok_i,
  input  vsa_pkg::commit_t        commit,
  output vsa_pkg::tok_t           tok_o
);
  import vsa_pkg::*;

  logic               free_r,  free_nxt;
  logic [ID_W-1:0]    id_r,    id_nxt;
  logic [CH_W-1:0]    ch_r,    ch_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  tok_t               tok_r,   tok_nxt;
  logic               hit;

  assign hit = (SLOT_W'(cell_idx) == tok_i.idx);

  // Update the token and the slot state
  always_comb begin
    tok_nxt   = tok_i;
    free_nxt  = free_r;
    id_nxt    = id_r;
    ch_nxt    = ch_r;
    stamp_nxt = stamp_r;
    if (tok_i.valid) begin
      case (tok_i.cmd)
        CMD_ASSIGN: begin
          if (!tok_i.found) begin
            if (free_r) begin
              tok_nxt.found    = 1'b1;
              tok_nxt.best_idx = cell_idx;
            end else if (stamp_r < tok_i.best_stamp) begin
              tok_nxt.best_stamp = stamp_r;
              tok_nxt.best_idx   = cell_idx;
            end
          end
        end
        CMD_RELEASE: begin
          if (hit) begin
            free_nxt = 1'b1;
            id_nxt   = '0;
            ch_nxt   = '0;
          end
        end
        CMD_QUERY: begin
          if (hit) begin
            tok_nxt.owner_id = id_r;
            tok_nxt.owner_ch = ch_r;
          end
        end
        default: begin
        end
      endcase
    end
    // Take the slot chosen by an assign
    if (commit.en && (commit.sel == cell_idx)) begin
      free_nxt  = 1'b0;
      id_nxt    = commit.eid;
      ch_nxt    = commit.ech;
      stamp_nxt = commit.stamp;
    end
  end

  // Hold slot state and advance the token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= 1'b1;
      id_r    <= '0;
      ch_r    <= '0;
      stamp_r <= '0;
      tok_r   <= '0;
    end else begin
      free_r  <= free_nxt;
      id_r    <= id_nxt;
      ch_r    <= ch_nxt;
      stamp_r <= stamp_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== rtl/core/vsa_checker.sv =====
// ----------------------------------------------------------------------------
// vsa_checker
// Port-level checks on the allocator's request and result timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vsa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic [vsa_pkg::ID_W-1:0]    out_owner_id,
  input logic [vsa_pkg::CH_W-1:0]    out_owner_channel,
  input logic                        out_stolen,
  input logic                        out_status
);
  import vsa_pkg::*;

  // A taken request keeps the block busy
  `VSA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // The result shows exactly when busy falls
  `VSA_ASSERT_SAME(a_result_idle, out_strobe, !busy)
  `VSA_ASSERT_SAME(a_fall_result, $fell(busy), out_strobe)

  // The result strobe is never high in back-to-back cycles
  `VSA_ASSERT_NEXT(a_single_pulse, out_strobe, !out_strobe)

  // A steal carries no owner and no range error
  `VSA_ASSERT_SAME(a_steal_clean, out_strobe && out_stolen,
                   out_owner_id == '0 && out_owner_channel == '0 && !out_status)

endmodule

bind voice_slot_allocator_oldest_steal vsa_checker u_vsa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_owner_id      (out_owner_id),
  .out_owner_channel (out_owner_channel),
  .out_stolen        (out_stolen),
  .out_status        (out_status)
);
